// ===== design/lcd_mode_and_scanline_timing_assert.svh =====
// ----------------------------------------------------------------------------
// LCD mode and scanline timing - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LCD_MODE_AND_SCANLINE_TIMING_ASSERT_SVH
`define LCD_MODE_AND_SCANLINE_TIMING_ASSERT_SVH

// same-cycle implication
`define LMST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LMST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lmst_pkg.sv =====
// ----------------------------------------------------------------------------
// lmst_pkg
// Types and constants shared by the LCD mode and scanline timing block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lmst_pkg;

  localparam int CNT_W = 10;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  // bit positions in stat_int_enables
  localparam int EN_HBLANK = 0;
  localparam int EN_VBLANK = 1;
  localparam int EN_OAM    = 2;
  localparam int EN_COIN   = 3;

  localparam logic [7:0] VBLANK_LINE = 8'd144;
  localparam logic [7:0] LAST_LINE   = 8'd153;

  localparam logic signed [CNT_W-1:0] OAM_ABOVE = 10'sd376;
  localparam logic signed [CNT_W-1:0] XFER_FROM = 10'sd204;

  typedef struct packed {
    logic [7:0] cycles;
    logic       lcd_enable;
    logic [3:0] stat_int_enables;
    logic [7:0] ly_compare;
  } item_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] cnt;
    logic [7:0]              line;
    mode_t                   mode;
    logic                    coin;
  } state_t;

  typedef struct packed {
    mode_t      mode;
    logic       coincidence;
    logic [7:0] scanline;
    logic       vblank_irq;
    logic       stat_irq;
    logic       draw_request;
    logic [7:0] draw_line;
  } result_t;

endpackage

`default_nettype wire

// ===== design/lmst_step.sv =====
// ----------------------------------------------------------------------------
// lmst_step
// Next-state and result logic for one timing update request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmst_step #(
  parameter int LINE_CYCLES = 456
) (
  input  wire lmst_pkg::item_t   item,
  input  wire lmst_pkg::state_t  st,
  output lmst_pkg::state_t       st_nxt,
  output lmst_pkg::result_t      res
);

  localparam logic signed [lmst_pkg::CNT_W-1:0] RELOAD =
    lmst_pkg::CNT_W'(LINE_CYCLES);

  lmst_pkg::mode_t             mode;
  logic                        want;
  logic                        coin;
  logic signed [lmst_pkg::CNT_W:0] diff;
  logic [7:0]                  nl;

  always_comb begin
    st_nxt           = st;
    res              = '0;
    mode             = lmst_pkg::MODE_HBLANK;
    want             = 1'b0;
    coin             = 1'b0;
    nl               = 8'(st.line + 8'd1);
    diff             = {st.cnt[lmst_pkg::CNT_W-1], st.cnt} -
                       $signed({3'b000, item.cycles});

    if (!item.lcd_enable) begin
      st_nxt.cnt  = RELOAD;
      st_nxt.line = 8'd0;
      st_nxt.mode = lmst_pkg::MODE_VBLANK;
    end else begin
      if (st.line >= lmst_pkg::VBLANK_LINE) begin
        mode = lmst_pkg::MODE_VBLANK;
        want = item.stat_int_enables[lmst_pkg::EN_VBLANK];
      end else if (st.cnt > lmst_pkg::OAM_ABOVE) begin
        mode = lmst_pkg::MODE_OAM;
        want = item.stat_int_enables[lmst_pkg::EN_OAM];
      end else if (st.cnt >= lmst_pkg::XFER_FROM) begin
        mode = lmst_pkg::MODE_XFER;
        want = 1'b0;
      end else begin
        mode = lmst_pkg::MODE_HBLANK;
        want = item.stat_int_enables[lmst_pkg::EN_HBLANK];
      end
      res.stat_irq = want && (mode != st.mode);
      st_nxt.mode  = mode;

      coin        = (st.line == item.ly_compare);
      st_nxt.coin = coin;
      if (coin && item.stat_int_enables[lmst_pkg::EN_COIN]) begin
        res.stat_irq = 1'b1;
      end

      if (diff <= 0) begin
        st_nxt.cnt = RELOAD;
        if (nl == lmst_pkg::VBLANK_LINE) begin
          st_nxt.line    = nl;
          res.vblank_irq = 1'b1;
        end else if (nl > lmst_pkg::LAST_LINE) begin
          st_nxt.line = 8'd0;
        end else begin
          // lines 1..143 are drawn, vblank lines 145..153 only advance
          st_nxt.line      = nl;
          res.draw_request = (nl < lmst_pkg::VBLANK_LINE);
          res.draw_line    = (nl < lmst_pkg::VBLANK_LINE) ? nl : 8'd0;
        end
      end else begin
        st_nxt.cnt = diff[lmst_pkg::CNT_W-1:0];
      end
    end

    res.mode        = st_nxt.mode;
    res.coincidence = st_nxt.coin;
    res.scanline    = st_nxt.line;
  end

endmodule

`default_nettype wire

// ===== design/lmst_timing.sv =====
// ----------------------------------------------------------------------------
// lmst_timing
// Input register and timing state; one request is applied per advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmst_timing #(
  parameter int LINE_CYCLES = 456
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     load,
  input  wire lmst_pkg::item_t    item_in,
  input  wire                     advance,
  output logic                    item_valid,
  output lmst_pkg::result_t       res
);

  `include "lcd_mode_and_scanline_timing_assert.svh"

  logic              item_valid_r;
  lmst_pkg::item_t   item_r;
  lmst_pkg::state_t  st_r;
  lmst_pkg::state_t  st_nxt;

  lmst_step #(
    .LINE_CYCLES (LINE_CYCLES)
  ) u_step (
    .item   (item_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      st_r         <= '0;
    end else begin
      if (load) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

  assign item_valid = item_valid_r;

  `LMST_ASSERT_IMP(a_line_range, 1'b1, st_r.line <= lmst_pkg::LAST_LINE,
    "scanline beyond last line")
  `LMST_ASSERT_IMP(a_cnt_range, 1'b1,
    st_r.cnt >= 0 && st_r.cnt <= lmst_pkg::CNT_W'(LINE_CYCLES),
    "line cycle counter out of range")
  `LMST_ASSERT_NXT(a_disable, advance && !item_r.lcd_enable,
    st_r.mode == lmst_pkg::MODE_VBLANK && st_r.line == 8'd0,
    "disabled display did not force mode 1 and line 0")

endmodule

`default_nettype wire

// ===== design/lcd_mode_and_scanline_timing.sv =====
// ----------------------------------------------------------------------------
// lcd_mode_and_scanline_timing
// LCD status mode, scanline counter and status/vblank interrupt requests.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_      | input     | in_valid/in_stall  | cycles, lcd_enable, enables, compare
//  out_     | output    | out_valid/out_stall| mode, flags, scanline, irqs, draw
//
// One request per clock unless out_ stalls; a request passes the input register
// and then the result register, with the timing state updated as it leaves the input
// register. Reset (rst_n low, synchronous) clears the state to line 0,
// counter 0, mode 0. A stall on out_ holds the result register; the input
// register then fills and in_stall rises in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcd_mode_and_scanline_timing #(
  parameter int LINE_CYCLES = 456
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [7:0]  in_cycles,
  input  wire        in_lcd_enable,
  input  wire [3:0]  in_stat_int_enables,
  input  wire [7:0]  in_ly_compare,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] out_mode,
  output logic       out_coincidence,
  output logic [7:0] out_scanline,
  output logic       out_vblank_irq,
  output logic       out_stat_irq,
  output logic       out_draw_request,
  output logic [7:0] out_draw_line
);

  `include "lcd_mode_and_scanline_timing_assert.svh"

  lmst_pkg::item_t    item_in;
  lmst_pkg::result_t  res;
  lmst_pkg::result_t  res_r;
  logic               out_valid_r;
  logic               item_valid;
  logic               out_free;
  logic               advance;
  logic               load;

  assign item_in.cycles           = in_cycles;
  assign item_in.lcd_enable       = in_lcd_enable;
  assign item_in.stat_int_enables = in_stat_int_enables;
  assign item_in.ly_compare       = in_ly_compare;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = item_valid && out_free;
  assign in_stall = item_valid && !out_free;
  assign load     = in_valid && !in_stall;

  lmst_timing #(
    .LINE_CYCLES (LINE_CYCLES)
  ) u_timing (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .item_in    (item_in),
    .advance    (advance),
    .item_valid (item_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mode         = res_r.mode;
  assign out_coincidence  = res_r.coincidence;
  assign out_scanline     = res_r.scanline;
  assign out_vblank_irq   = res_r.vblank_irq;
  assign out_stat_irq     = res_r.stat_irq;
  assign out_draw_request = res_r.draw_request;
  assign out_draw_line    = res_r.draw_line;

  `LMST_ASSERT_IMP(a_draw_line, out_valid_r && out_draw_request,
    out_draw_line == out_scanline && out_draw_line != 8'd0,
    "draw request for wrong line")
  `LMST_ASSERT_IMP(a_no_draw_zero, out_valid_r && !out_draw_request,
    out_draw_line == 8'd0, "draw line set without request")
  `LMST_ASSERT_IMP(a_vblank, out_valid_r && out_vblank_irq,
    out_scanline == lmst_pkg::VBLANK_LINE && !out_draw_request,
    "vblank request off line 144")

endmodule

`default_nettype wire

// ===== bench/tb_lcd_mode_and_scanline_timing.sv =====
// ----------------------------------------------------------------------------
// tb_lcd_mode_and_scanline_timing
// Self-checking bench for the LCD mode and scanline timing block. Requests
// go in through a valid/stall sender with random gaps. A shadow timing model
// predicts mode, coincidence, scanline, interrupts and draw requests for each
// accepted request. A checker with random stalls compares every result
// against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lcd_mode_and_scanline_timing;

  localparam int LINE_CYCLES  = 456;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 60000;
  localparam int IDLE_PCT     = 23;
  localparam int DRAIN_CYCLES = 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_cycles = 8'd0;
  logic       in_lcd_enable = 1'b0;
  logic [3:0] in_stat_int_enables = 4'd0;
  logic [7:0] in_ly_compare = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_mode;
  logic       out_coincidence;
  logic [7:0] out_scanline;
  logic       out_vblank_irq;
  logic       out_stat_irq;
  logic       out_draw_request;
  logic [7:0] out_draw_line;

  lcd_mode_and_scanline_timing #(
    .LINE_CYCLES(LINE_CYCLES)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cycles           (in_cycles),
    .in_lcd_enable       (in_lcd_enable),
    .in_stat_int_enables (in_stat_int_enables),
    .in_ly_compare       (in_ly_compare),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_mode            (out_mode),
    .out_coincidence     (out_coincidence),
    .out_scanline        (out_scanline),
    .out_vblank_irq      (out_vblank_irq),
    .out_stat_irq        (out_stat_irq),
    .out_draw_request    (out_draw_request),
    .out_draw_line       (out_draw_line)
  );

  always #5 clk = ~clk;

  // shadow timing state
  logic signed [lmst_pkg::CNT_W-1:0] lt_cnt = '0;
  logic [7:0]                        lt_line = '0;
  lmst_pkg::mode_t                   lt_mode = lmst_pkg::MODE_HBLANK;
  logic                              lt_coin = 1'b0;

  lmst_pkg::result_t pending_results[$];
  int                mismatch_count = 0;
  int                cycle_count = 0;
  bit                no_idle = 1'b0;

  function automatic lmst_pkg::result_t predict_timing(input lmst_pkg::item_t it);
    lmst_pkg::result_t r;
    lmst_pkg::mode_t   m;
    logic              want;
    int                cnt;
    r = '0;
    if (!it.lcd_enable) begin
      lt_cnt  = lmst_pkg::CNT_W'(LINE_CYCLES);
      lt_line = 8'd0;
      lt_mode = lmst_pkg::MODE_VBLANK;
    end else begin
      // mode comes from the counter before this request's cycles are spent
      if (lt_line >= lmst_pkg::VBLANK_LINE) begin
        m    = lmst_pkg::MODE_VBLANK;
        want = it.stat_int_enables[lmst_pkg::EN_VBLANK];
      end else if (lt_cnt > lmst_pkg::OAM_ABOVE) begin
        m    = lmst_pkg::MODE_OAM;
        want = it.stat_int_enables[lmst_pkg::EN_OAM];
      end else if (lt_cnt >= lmst_pkg::XFER_FROM) begin
        m    = lmst_pkg::MODE_XFER;
        want = 1'b0;
      end else begin
        m    = lmst_pkg::MODE_HBLANK;
        want = it.stat_int_enables[lmst_pkg::EN_HBLANK];
      end
      if (want && m != lt_mode) r.stat_irq = 1'b1;
      lt_mode = m;

      lt_coin = (lt_line == it.ly_compare);
      if (lt_coin && it.stat_int_enables[lmst_pkg::EN_COIN]) r.stat_irq = 1'b1;

      cnt = lt_cnt;
      cnt = cnt - int'(it.cycles);
      if (cnt <= 0) begin
        lt_cnt  = lmst_pkg::CNT_W'(LINE_CYCLES);
        lt_line = lt_line + 8'd1;
        if (lt_line == lmst_pkg::VBLANK_LINE) begin
          r.vblank_irq = 1'b1;
        end else if (lt_line > lmst_pkg::LAST_LINE) begin
          lt_line = 8'd0;
        end else if (lt_line < lmst_pkg::VBLANK_LINE) begin
          r.draw_request = 1'b1;
          r.draw_line    = lt_line;
        end
      end else begin
        lt_cnt = cnt[lmst_pkg::CNT_W-1:0];
      end
    end
    r.mode        = lt_mode;
    r.coincidence = lt_coin;
    r.scanline    = lt_line;
    return r;
  endfunction

  // Entered just after a rising edge; returns just after the edge that took the request.
  task automatic send_update(input lmst_pkg::item_t it);
    lmst_pkg::result_t exp_r;
    bit                taken;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_cycles           <= it.cycles;
    in_lcd_enable       <= it.lcd_enable;
    in_stat_int_enables <= it.stat_int_enables;
    in_ly_compare       <= it.ly_compare;
    // stall is read once it has settled, ahead of the edge it applies to
    do begin
      #1;
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    exp_r = predict_timing(it);
    pending_results.insert(pending_results.size(), exp_r);
  endtask

  function automatic lmst_pkg::item_t make_update(input logic [7:0] cyc, input logic en,
                                                  input logic [3:0] ints,
                                                  input logic [7:0] cmp);
    lmst_pkg::item_t it;
    it.cycles           = cyc;
    it.lcd_enable       = en;
    it.stat_int_enables = ints;
    it.ly_compare       = cmp;
    return it;
  endfunction

  // result checker and receiver stall; handshake is read after it settles
  initial begin
    lmst_pkg::result_t exp_r;
    lmst_pkg::result_t got;
    forever begin
      @(posedge clk);
      out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
      #1;
      if (rst_n && out_valid && !out_stall) begin
        got.mode         = lmst_pkg::mode_t'(out_mode);
        got.coincidence  = out_coincidence;
        got.scanline     = out_scanline;
        got.vblank_irq   = out_vblank_irq;
        got.stat_irq     = out_stat_irq;
        got.draw_request = out_draw_request;
        got.draw_line    = out_draw_line;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: mode=%0d line=%0d", got.mode, got.scanline);
        end else begin
          exp_r = pending_results.pop_front();
          if (got.mode !== exp_r.mode || got.coincidence !== exp_r.coincidence ||
              got.scanline !== exp_r.scanline || got.vblank_irq !== exp_r.vblank_irq ||
              got.stat_irq !== exp_r.stat_irq || got.draw_request !== exp_r.draw_request ||
              got.draw_line !== exp_r.draw_line) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: exp mode=%0d coin=%0b line=%0d vbl=%0b stat=%0b draw=%0b/%0d",
                       exp_r.mode, exp_r.coincidence, exp_r.scanline, exp_r.vblank_irq,
                       exp_r.stat_irq, exp_r.draw_request, exp_r.draw_line);
              $display("          got mode=%0d coin=%0b line=%0d vbl=%0b stat=%0b draw=%0b/%0d",
                       got.mode, got.coincidence, got.scanline, got.vblank_irq,
                       got.stat_irq, got.draw_request, got.draw_line);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // first requests out of reset: counter at zero, coincidence on line 0
  task automatic test_reset_state();
    send_update(make_update(8'd0, 1'b1, 4'b1000, 8'd0));
    send_update(make_update(8'd255, 1'b1, 4'b1111, 8'd1));
    send_update(make_update(8'd255, 1'b1, 4'b0000, 8'd255));
  endtask

  // small steps across one line: oam, transfer, hblank, then advance
  task automatic test_line_modes();
    int k;
    for (k = 0; k < 13; k++)
      send_update(make_update(8'd40, 1'b1, 4'b0111, 8'd255));
  endtask

  task automatic test_display_disable();
    send_update(make_update(8'd255, 1'b0, 4'b1111, 8'd0));
    send_update(make_update(8'd0, 1'b0, 4'b0000, 8'd255));
    // re-enable on line 0 with coincidence and an oam entry
    send_update(make_update(8'd0, 1'b1, 4'b1111, 8'd0));
    send_update(make_update(8'd255, 1'b1, 4'b1111, 8'd0));
    send_update(make_update(8'd255, 1'b1, 4'b1111, 8'd1));
    send_update(make_update(8'd1, 1'b1, 4'b1010, 8'd2));
  endtask

  // mostly enabled so several frames pass through vblank and wrap;
  // the tail adds disable noise
  task automatic test_random_frames();
    lmst_pkg::item_t it;
    int              k;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      no_idle = (k >= 400 && k < 700);
      if ($urandom_range(99) < 60) it.cycles = 8'($urandom_range(255));
      else it.cycles = 8'($urandom_range(63));
      if (k < RANDOM_ITEMS - 150) it.lcd_enable = 1'b1;
      else it.lcd_enable = ($urandom_range(19) != 0);
      it.stat_int_enables = 4'($urandom_range(15));
      if ($urandom_range(1) == 0) it.ly_compare = lt_line - 8'd1 + 8'($urandom_range(2));
      else it.ly_compare = 8'($urandom_range(255));
      send_update(it);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_line_modes();
    test_display_disable();
    test_random_frames();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
